>>> src/content_pattern_scanner_macros.svh
// ---------------------------------------------------------------------------
// content_pattern_scanner_macros.svh
// Assertion macros shared by the checker of the content pattern scanner.
// ---------------------------------------------------------------------------
`ifndef CONTENT_PATTERN_SCANNER_MACROS_SVH
`define CONTENT_PATTERN_SCANNER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define CPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define CPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/cps_pkg.sv
// ---------------------------------------------------------------------------
// cps_pkg
// Types, codes, pattern table and compare functions of the content scanner.
// ---------------------------------------------------------------------------
package cps_pkg;

	localparam int PATTERN_COUNT = 29;
	localparam int HISTORY_DEPTH = 13;
	localparam int WINDOW_LEN    = HISTORY_DEPTH + 1;
	localparam int PAT_MAX_LEN   = 14;
	localparam int PAT_BITS      = 8 * PAT_MAX_LEN;

	localparam int LEN_W   = 25;
	localparam int MAXL_W  = 24;
	localparam int TAG_W   = 16;
	localparam int IDX_W   = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;

	typedef logic [1:0]       verdict_t;
	typedef logic [IDX_W-1:0] pat_idx_t;
	typedef logic [TAG_W-1:0] tag_cnt_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [PATTERN_COUNT-1:0] hit_mask_t;

	// Verdict codes
	localparam verdict_t VERDICT_PASS     = 2'd0;
	localparam verdict_t VERDICT_TOO_LONG = 2'd1;
	localparam verdict_t VERDICT_PATTERN  = 2'd2;
	localparam verdict_t VERDICT_TAGS     = 2'd3;

	localparam pat_idx_t NO_PATTERN = pat_idx_t'(31);

	// Register indexes
	localparam cfg_idx_t CFG_MAX_LENGTH = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_TAG_LIMIT  = cfg_idx_t'(1);

	localparam logic [MAXL_W-1:0] MAX_LENGTH_RST = MAXL_W'(10 * 1024 * 1024);
	localparam tag_cnt_t          TAG_LIMIT_RST  = TAG_W'(1000);

	localparam logic [7:0] CHAR_LT = 8'h3C;
	localparam logic [7:0] CHAR_GT = 8'h3E;

	// Patterns, right aligned: last character in bits [7:0]
	localparam logic [PAT_BITS-1:0] PAT_TEXT [PATTERN_COUNT] = '{
		"javascript:", "vbscript:", "<script", "</script>",
		"eval(", "document.", "window.", "alert(",
		"file://", "ftp://", "data:", "blob:",
		"onload=", "onerror=", "onclick=", "onmouseover=",
		"\\x", "\\u", "%3c", "%3e",
		"&#x", "&#", "expression(", "behavior:",
		"binding:", "import(", "require(", "fetch(",
		"xmlhttprequest"
	};

	localparam logic [3:0] PAT_LEN [PATTERN_COUNT] = '{
		4'd11, 4'd9, 4'd7, 4'd9, 4'd5, 4'd9, 4'd7, 4'd6,
		4'd7, 4'd6, 4'd5, 4'd5, 4'd7, 4'd8, 4'd8, 4'd12,
		4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd2, 4'd11, 4'd9,
		4'd8, 4'd7, 4'd8, 4'd6, 4'd14
	};

	// ASCII-only case fold
	function automatic logic [7:0] fold_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c | 8'h20;
		end
		return r;
	endfunction

	// Window entry 0 is the current byte, entry k the byte k items back
	function automatic hit_mask_t match_mask(input logic [7:0] win [WINDOW_LEN]);
		hit_mask_t m;
		m = '0;
		for (int p = 0; p < PATTERN_COUNT; p++) begin
			m[p] = 1'b1;
			for (int k = 0; k < PAT_MAX_LEN; k++) begin
				if (k < int'(PAT_LEN[p]) && win[k] != PAT_TEXT[p][8*k +: 8]) begin
					m[p] = 1'b0;
				end
			end
		end
		return m;
	endfunction

	// Lowest set bit, NO_PATTERN when empty
	function automatic pat_idx_t lowest_hit(input hit_mask_t m);
		pat_idx_t idx;
		idx = NO_PATTERN;
		for (int p = PATTERN_COUNT - 1; p >= 0; p--) begin
			if (m[p]) begin
				idx = pat_idx_t'(p);
			end
		end
		return idx;
	endfunction

endpackage

>>> src/cps_if.sv
// ---------------------------------------------------------------------------
// cps_if
// Valid/ready channels of the content scanner: byte input and verdict output.
// ---------------------------------------------------------------------------
interface cps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last;

	modport source (output valid, output text_byte, output last, input ready);
	modport sink   (input valid, input text_byte, input last, output ready);
endinterface

interface cps_out_if;
	logic              valid;
	logic              ready;
	cps_pkg::verdict_t verdict;
	cps_pkg::pat_idx_t pattern_index;
	cps_pkg::tag_cnt_t tag_total;

	modport source (output valid, output verdict, output pattern_index,
		output tag_total, input ready);
	modport sink   (input valid, input verdict, input pattern_index,
		input tag_total, output ready);
endinterface

>>> src/content_pattern_scanner.sv
// ---------------------------------------------------------------------------
// content_pattern_scanner
// Byte-stream content filter: length, pattern and tag checks per stream.
// ---------------------------------------------------------------------------
// Takes one text byte per clock while not stalled and answers only on the
// byte marked last, with one verdict item (too long, pattern found, too
// many tags, or pass, in that priority), the lowest matching pattern index
// and the tag count. An item is registered on entry, compared against the
// 13 byte history, and a last byte's verdict then lands in the output
// register; the sustained rate is one byte per cycle while not stalled,
// limited by the single compare stage. A stalled verdict holds the input
// side only when a further last byte needs the output register. Stream
// state clears after each last byte; max_length and tag_limit keep their
// values and are written through cfg_we.
// ---------------------------------------------------------------------------
module content_pattern_scanner (
	input  logic                clk,
	input  logic                arst_n,
	cps_in_if.sink              in_ch,
	cps_out_if.source           out_ch,
	input  logic                cfg_we,
	input  cps_pkg::cfg_idx_t   cfg_index,
	input  cps_pkg::cfg_data_t  cfg_wdata
);
	import cps_pkg::*;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Stream state
	logic [LEN_W-1:0]  length_q;
	logic [7:0]        recent_q [HISTORY_DEPTH];
	hit_mask_t         hits_q;
	logic              inside_tag_q;
	tag_cnt_t          tag_count_q;

	// Registers
	logic [MAXL_W-1:0] max_length_q;
	tag_cnt_t          tag_limit_q;

	// Output register
	logic     out_valid_q;
	verdict_t verdict_q;
	pat_idx_t pidx_q;
	tag_cnt_t tag_total_q;

	logic              adv_s1;
	logic [7:0]        cur;
	logic [7:0]        win [WINDOW_LEN];
	hit_mask_t         hits_nxt;
	logic [LEN_W-1:0]  length_nxt;
	logic              inside_nxt;
	tag_cnt_t          tag_nxt;
	pat_idx_t          pidx_nxt;
	verdict_t          verdict_nxt;

	// Stage 1 moves unless it holds a last byte and the output is blocked
	assign adv_s1      = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	// Compare window and next state
	always_comb begin
		cur    = fold_lower(byte_s1);
		win[0] = cur;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			win[i+1] = recent_q[i];
		end
		hits_nxt   = hits_q | match_mask(win);
		length_nxt = (length_q == {LEN_W{1'b1}}) ? length_q : length_q + LEN_W'(1);
		inside_nxt = inside_tag_q;
		tag_nxt    = tag_count_q;
		if (!inside_tag_q) begin
			if (cur == CHAR_LT) begin
				inside_nxt = 1'b1;
			end
		end else if (cur == CHAR_GT) begin
			inside_nxt = 1'b0;
			if (tag_count_q != {TAG_W{1'b1}}) begin
				tag_nxt = tag_count_q + TAG_W'(1);
			end
		end
		pidx_nxt = lowest_hit(hits_nxt);
		if (length_nxt > {1'b0, max_length_q}) begin
			verdict_nxt = VERDICT_TOO_LONG;
		end else if (pidx_nxt != NO_PATTERN) begin
			verdict_nxt = VERDICT_PATTERN;
		end else if (tag_nxt > tag_limit_q) begin
			verdict_nxt = VERDICT_TAGS;
		end else begin
			verdict_nxt = VERDICT_PASS;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.text_byte;
			last_s1 <= in_ch.last;
		end
	end

	// Stream state update, cleared after a last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q     <= '0;
			hits_q       <= '0;
			inside_tag_q <= 1'b0;
			tag_count_q  <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				recent_q[i] <= '0;
			end
		end else if (adv_s1) begin
			if (last_s1) begin
				length_q     <= '0;
				hits_q       <= '0;
				inside_tag_q <= 1'b0;
				tag_count_q  <= '0;
				for (int i = 0; i < HISTORY_DEPTH; i++) begin
					recent_q[i] <= '0;
				end
			end else begin
				length_q     <= length_nxt;
				hits_q       <= hits_nxt;
				inside_tag_q <= inside_nxt;
				tag_count_q  <= tag_nxt;
				recent_q[0]  <= cur;
				for (int i = 1; i < HISTORY_DEPTH; i++) begin
					recent_q[i] <= recent_q[i-1];
				end
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
			tag_limit_q  <= TAG_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_LENGTH: max_length_q <= cfg_wdata[MAXL_W-1:0];
				CFG_TAG_LIMIT:  tag_limit_q  <= cfg_wdata[TAG_W-1:0];
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			verdict_q   <= verdict_nxt;
			pidx_q      <= pidx_nxt;
			tag_total_q <= tag_nxt;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.verdict       = verdict_q;
	assign out_ch.pattern_index = pidx_q;
	assign out_ch.tag_total     = tag_total_q;

endmodule

>>> src/cps_checker.sv
// ---------------------------------------------------------------------------
// cps_checker
// Port-level checks of the content scanner, bound to the top level.
// ---------------------------------------------------------------------------
`include "content_pattern_scanner_macros.svh"

module cps_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input cps_pkg::verdict_t verdict,
	input cps_pkg::pat_idx_t pattern_index,
	input cps_pkg::tag_cnt_t tag_total
);
	import cps_pkg::*;

	// A stalled verdict item keeps its contents
	`CPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(verdict) && $stable(pattern_index) && $stable(tag_total), "stalled verdict item changed")

	// Pattern verdict always names a pattern
	`CPS_ASSERT_NOW(a_pat_named, out_valid && verdict == VERDICT_PATTERN, pattern_index != NO_PATTERN, "pattern verdict without index")

	// Pass and tag verdicts mean no pattern was seen
	`CPS_ASSERT_NOW(a_no_pat, out_valid && (verdict == VERDICT_PASS || verdict == VERDICT_TAGS), pattern_index == NO_PATTERN, "pattern index with non-pattern verdict")

	// Index is a real pattern or the none code
	`CPS_ASSERT_NOW(a_idx_range, out_valid, pattern_index < pat_idx_t'(PATTERN_COUNT) || pattern_index == NO_PATTERN, "pattern index out of range")

endmodule

bind content_pattern_scanner cps_checker u_cps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.verdict       (out_ch.verdict),
	.pattern_index (out_ch.pattern_index),
	.tag_total     (out_ch.tag_total)
);
